// ===== design/cdq_pkg.sv =====
package cdq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture item, start slot read
        logic exec;     // apply operation, register result
    } t_dp_cmd;

endpackage

// ===== design/cdq_ctrl.sv =====
module cdq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output cdq_pkg::t_dp_cmd o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state == S_EXEC);

endmodule

// ===== design/cdq_datapath.sv =====
module cdq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdq_pkg::t_dp_cmd   i_cmd,
    input  cdq_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output cdq_pkg::t_out_item o_result
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] r_slots [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]         r_head, n_head;
    logic [IDX_W-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_strobe;
    t_out_item                r_result, n_result;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_front;
    logic [IDX_W-1:0]         rd_addr;
    logic                     is_full, is_empty;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // read address is taken from the indices as they stand when the item arrives
    assign rd_front = (i_item.opcode == OP_POP_FRONT) || (i_item.opcode == OP_PEEK_FRONT);
    assign rd_addr  = rd_front ? r_head : r_tail;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        n_head          = r_head;
        n_tail          = r_tail;
        n_count         = r_count;
        wr_en           = 1'b0;
        wr_addr         = '0;
        n_result.status = STAT_DONE;
        n_result.data   = '0;
        unique case (r_op) inside
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (is_full) begin
                    n_result.status = STAT_FULL;
                end else begin
                    wr_en = 1'b1;
                    if (is_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        wr_addr = '0;
                    end else if (r_op == OP_PUSH_FRONT) begin
                        n_head  = wrap_dec(r_head);
                        wr_addr = n_head;
                    end else begin
                        n_tail  = wrap_inc(r_tail);
                        wr_addr = n_tail;
                    end
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
                if (is_empty) begin
                    n_result.status = STAT_EMPTY;
                end else begin
                    n_result.data = r_rdata;
                    if (r_op == OP_POP_FRONT) begin
                        n_head  = wrap_inc(r_head);
                        n_count = r_count - 1'b1;
                    end else if (r_op == OP_POP_REAR) begin
                        n_tail  = wrap_dec(r_tail);
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: ;  // unused codes: no operation
        endcase
        n_result.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdata <= r_slots[rd_addr];
        end
        if (i_cmd.exec && wr_en) begin
            r_slots[wr_addr] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_item.opcode;
            r_value <= i_item.value;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== design/circular_deque_unit.sv =====
// Double-ended queue over a circular store of DEPTH signed 32-bit words.
// Input: drive i_item (opcode, value) with start high; the item is taken
// at the clock edge where start is high and busy is low.
// Opcodes: push front, push rear, pop front, pop rear, peek front, peek rear.
// Output: one result item per input item, on o_result for exactly one cycle
// while o_strobe is high. status reports done, full (push refused) or empty
// (pop or peek refused); data carries the removed or peeked word, else zero;
// occupancy is the element count after the operation.
// Timing: the slot is read into a register at the edge where the item is
// taken, the index update runs in the following execute cycle, and the
// result strobe is high in the cycle after that. busy is high during the
// execute cycle only, so a new item is taken while the previous result is
// shown.
// Reset (synchronous, active low) empties the deque and clears the indices;
// the slot store itself is not cleared. The receiver cannot stall: each
// result is taken in its strobe cycle.
module circular_deque_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cdq_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output cdq_pkg::t_out_item o_result
);
    import cdq_pkg::*;

    t_dp_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    cdq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== sim/tb_circular_deque_unit.sv =====
module tb_circular_deque_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    // opcodes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int ITEMS_PER_PHASE = 210;

    typedef struct {
        t_in_item    item;
        int unsigned idle_pct;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_strobe;
    t_out_item o_result;

    t_pending  pending_ops[$];
    t_out_item expected_results[$];
    int        errors = 0;
    int        stall_cycles = 0;

    // shadow deque state
    logic signed [DATA_W-1:0] dq_slots[DEPTH];
    logic [IDX_W-1:0]         dq_head = '0;
    logic [IDX_W-1:0]         dq_tail = '0;
    logic [CNT_W-1:0]         dq_count = '0;

    circular_deque_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    task automatic deque_apply(input t_in_item it, output t_out_item res);
        res = '0;
        res.status = STAT_DONE;
        unique case (it.opcode) inside
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (dq_count >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    if (dq_count == 0) begin
                        // an empty deque restarts at slot 0
                        dq_head = '0;
                        dq_tail = '0;
                        dq_slots[0] = it.value;
                    end else if (it.opcode == OP_PUSH_FRONT) begin
                        dq_head = idx_dec(dq_head);
                        dq_slots[dq_head] = it.value;
                    end else begin
                        dq_tail = idx_inc(dq_tail);
                        dq_slots[dq_tail] = it.value;
                    end
                    dq_count = dq_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
                if (dq_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    if (it.opcode == OP_POP_FRONT || it.opcode == OP_PEEK_FRONT)
                        res.data = dq_slots[dq_head];
                    else
                        res.data = dq_slots[dq_tail];
                    if (it.opcode == OP_POP_FRONT) begin
                        dq_head = idx_inc(dq_head);
                        dq_count = dq_count - 1'b1;
                    end else if (it.opcode == OP_POP_REAR) begin
                        dq_tail = idx_dec(dq_tail);
                        dq_count = dq_count - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(dq_count);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_proc
        t_pending  nxt;
        t_out_item predicted;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                deque_apply(i_item, predicted);
                expected_results.push_back(predicted);
            end
            // only move on once the current item has gone
            if (!start || !busy) begin
                if (pending_ops.size() > 0 &&
                    $urandom_range(99) >= pending_ops[0].idle_pct) begin
                    nxt = pending_ops.pop_front();
                    start  <= 1'b1;
                    i_item <= nxt.item;
                end else begin
                    start  <= 1'b0;
                    i_item <= {OP_W'($urandom), DATA_W'($urandom)};
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_proc
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: status=%0d data=%0d occupancy=%0d",
                         $time, o_result.status, o_result.data, o_result.occupancy);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_result.status);
                    errors++;
                end
                if (o_result.data !== want.data) begin
                    $display("%0t: data mismatch: expected %0d, got %0d",
                             $time, want.data, o_result.data);
                    errors++;
                end
                if (o_result.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy mismatch: expected %0d, got %0d",
                             $time, want.occupancy, o_result.occupancy);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_op(input logic [OP_W-1:0] opc, input logic [DATA_W-1:0] val,
                            input int unsigned pct);
        t_pending p;
        p.item.opcode = opc;
        p.item.value  = val;
        p.idle_pct    = pct;
        pending_ops.push_back(p);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [OP_W-1:0] take_ops[4];
        logic [OP_W-1:0] opc;
        int unsigned     pct;
        int unsigned     burst_len;
        int unsigned     push_weight;
        int              n;

        take_ops = '{OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR};

        // refusals on an empty deque, spare opcodes
        queue_op(OP_POP_FRONT,  32'h1234_5678, 0);
        queue_op(OP_POP_REAR,   32'hFFFF_FFFF, 0);
        queue_op(OP_PEEK_FRONT, 32'h0,         0);
        queue_op(OP_PEEK_REAR,  32'h8000_0000, 0);
        queue_op(OP_SPARE_6,    32'h7FFF_FFFF, 0);
        queue_op(OP_SPARE_7,    32'hAAAA_AAAA, 0);
        // fill from both ends, across the wrap point
        queue_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, 0);
        queue_op(OP_PUSH_REAR,  32'h8000_0000, 0);
        queue_op(OP_PUSH_FRONT, 32'h0000_0000, 0);
        queue_op(OP_PUSH_REAR,  32'hFFFF_FFFF, 0);
        queue_op(OP_PUSH_FRONT, 32'h5555_5555, 0);
        queue_op(OP_PUSH_REAR,  32'hAAAA_AAAA, 0);
        queue_op(OP_PUSH_FRONT, 32'h0000_0001, 0);
        queue_op(OP_PUSH_REAR,  32'hFFFF_FFFE, 0);
        // full: both pushes refused
        queue_op(OP_PUSH_FRONT, 32'h1111_1111, 0);
        queue_op(OP_PUSH_REAR,  32'h2222_2222, 0);
        queue_op(OP_PEEK_FRONT, 32'h0, 0);
        queue_op(OP_PEEK_REAR,  32'h0, 0);
        queue_op(OP_SPARE_7,    32'h0, 0);
        // drain down to the last element and past it
        for (int k = 0; k < 4; k++) begin
            queue_op(OP_POP_FRONT, $urandom, 0);
            queue_op(OP_POP_REAR,  $urandom, 0);
        end
        queue_op(OP_POP_FRONT, 32'h0, 0);

        // random phases: no gaps, heavy gaps, no gaps, light gaps
        for (int ph = 0; ph < 4; ph++) begin
            pct = (ph == 1) ? 69 : (ph == 3) ? 29 : 0;
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                // bursts biased towards filling or draining
                burst_len   = $urandom_range(4, 24);
                push_weight = $urandom_range(15, 85);
                for (int k = 0; k < burst_len; k++) begin
                    if ($urandom_range(99) < 3)
                        opc = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
                    else if ($urandom_range(99) < push_weight)
                        opc = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                    else
                        opc = take_ops[$urandom_range(3)];
                    queue_op(opc, rand_word(), pct);
                    n++;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || start) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/cdq_pkg.sv
design/cdq_ctrl.sv
design/cdq_datapath.sv
design/circular_deque_unit.sv
sim/tb_circular_deque_unit.sv
